// ===== sv/pwm_motor_speed_regulator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// pwm motor speed regulator assertion macros
// concurrent assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef PWM_MOTOR_SPEED_REGULATOR_UNIT_ASSERT_SVH
`define PWM_MOTOR_SPEED_REGULATOR_UNIT_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define PMSR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the default clk_i / rst_ni pair
`define PMSR_ASSERT_DEF(lbl, prop, msg) \
  `PMSR_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/pmsr_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsr_pkg
// shared constants, types and reciprocal factors of the speed regulator
// ----------------------------------------------------------------------------
package pmsr_pkg;

  localparam int unsigned TEETH          = 12;
  localparam int unsigned FULL_SCALE_RPM = 6600;

  localparam int unsigned TARGET_W = 13;
  localparam int unsigned WINDOW_W = 24;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned RPM_RAW_W = 20;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned TOOTH_W  = 14;
  localparam int unsigned PHASE_W  = 17;
  localparam int unsigned CFG_W    = 24;

  localparam logic [WINDOW_W-1:0]  WINDOW_RESET = 24'd3125000;
  localparam logic [TOOTH_W-1:0]   TOOTH_MAX    = 14'd16383;
  localparam logic [DUTY_W-1:0]    DUTY_MAX     = 7'd100;
  localparam logic [PHASE_W-1:0]   PERIOD_TICKS = 17'd65536;
  localparam logic [RPM_RAW_W-1:0] RPM_MAX      = 20'd65535;

  // duty = target * 100 / FULL_SCALE_RPM as one multiply and shift
  localparam int unsigned DUTY_SH = 34;
  localparam longint unsigned DUTY_K =
    64'd100 * (((64'd1 << DUTY_SH) + FULL_SCALE_RPM - 1) / FULL_SCALE_RPM);
  localparam int unsigned DUTY_KW = $clog2(DUTY_K + 1);

  // rpm = teeth * 60 / TEETH
  localparam int unsigned RPM_SH = 29;
  localparam longint unsigned RPM_K =
    64'd60 * (((64'd1 << RPM_SH) + TEETH - 1) / TEETH);
  localparam int unsigned RPM_KW = $clog2(RPM_K + 1);

  // high phase = duty * 65536 / 100, the 65536 folded into the shift
  localparam int unsigned HI_SH = 31;
  localparam longint unsigned HI_K = ((64'd1 << HI_SH) + 64'd99) / 64'd100;
  localparam int unsigned HI_KW = $clog2(HI_K + 1);
  localparam int unsigned HI_SHIFT = HI_SH - 16;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  typedef enum logic {
    REG_TARGET_RPM   = 1'b0,
    REG_WINDOW_TICKS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              window_done;
    logic [DUTY_W-1:0] duty_percent;
    logic [RPM_W-1:0]  measured_rpm;
    logic              pwm_level;
  } result_t;

endpackage

// ===== sv/pwm_motor_speed_regulator_unit.sv =====
// a result is registered and appears on m_axis in the cycle after its input transfer
// throughput: one item per cycle while the output is not stalled, set by the single state update per transfer
// s_axis_tready stays high while the output register is empty or being drained
// reset clears all counters, duty and speed, target to 0, window to 3125000 ticks
// ----------------------------------------------------------------------------
// pwm_motor_speed_regulator_unit
// timer-tick driven pwm motor speed regulator with streaming ports
// ----------------------------------------------------------------------------
module pwm_motor_speed_regulator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [0] pulse_edge
  input  logic                           s_axis_tuser,   // [0] mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,   // [0] pwm_level,
                                                         // [16:1] measured_rpm,
                                                         // [23:17] duty_percent
  output logic                           m_axis_tlast,   // window_done
  input  logic                           cfg_we_i,
  input  logic                           cfg_addr_i,
  input  logic [pmsr_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic [pmsr_pkg::TARGET_W-1:0] target_q;
  logic [pmsr_pkg::WINDOW_W-1:0] window_q;
  logic                          out_vld_q;
  pmsr_pkg::result_t             out_q;
  pmsr_pkg::result_t             result;
  logic                          in_xfer;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      window_q <= pmsr_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (pmsr_pkg::reg_idx_e'(cfg_addr_i))
        pmsr_pkg::REG_TARGET_RPM:   target_q <= cfg_wdata_i[pmsr_pkg::TARGET_W-1:0];
        pmsr_pkg::REG_WINDOW_TICKS: window_q <= cfg_wdata_i[pmsr_pkg::WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pmsr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_xfer),
    .mode_i         (pmsr_pkg::mode_e'(s_axis_tuser)),
    .pulse_edge_i   (s_axis_tdata[0]),
    .target_rpm_i   (target_q),
    .window_ticks_i (window_q),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_xfer) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.duty_percent, out_q.measured_rpm, out_q.pwm_level};
  assign m_axis_tlast  = out_q.window_done;

endmodule

// ===== sv/pmsr_core.sv =====
// ----------------------------------------------------------------------------
// pmsr_core
// regulator state and the single-pass next-state and result logic
// ----------------------------------------------------------------------------
module pmsr_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  pmsr_pkg::mode_e                      mode_i,
  input  logic                                 pulse_edge_i,
  input  logic [pmsr_pkg::TARGET_W-1:0]        target_rpm_i,
  input  logic [pmsr_pkg::WINDOW_W-1:0]        window_ticks_i,
  output pmsr_pkg::result_t                    result_o
);

  localparam int unsigned HI_PW   = pmsr_pkg::DUTY_W + pmsr_pkg::HI_KW;
  localparam int unsigned RPM_PW  = pmsr_pkg::TOOTH_W + pmsr_pkg::RPM_KW;
  localparam int unsigned DUTY_PW = pmsr_pkg::TARGET_W + pmsr_pkg::DUTY_KW;

  logic                            phase_q, phase_d;
  logic [pmsr_pkg::PHASE_W-1:0]    pcnt_q, pcnt_d;
  logic [pmsr_pkg::TOOTH_W-1:0]    tooth_q, tooth_d;
  logic [pmsr_pkg::WINDOW_W-1:0]   wcnt_q, wcnt_d;
  logic [pmsr_pkg::DUTY_W-1:0]     duty_q, duty_d;
  logic [pmsr_pkg::RPM_W-1:0]      rpm_q, rpm_d;

  logic [pmsr_pkg::TARGET_W-1:0]   tgt_eff;
  logic                            force_hi, force_lo;
  logic [HI_PW-1:0]                hi_prod;
  logic [pmsr_pkg::PHASE_W-1:0]    hi_len, lo_len;
  logic [RPM_PW-1:0]               rpm_prod;
  logic [pmsr_pkg::RPM_RAW_W-1:0]  rpm_raw;
  logic [pmsr_pkg::RPM_W-1:0]      rpm_sat;
  logic [DUTY_PW-1:0]              duty_prod;
  logic [pmsr_pkg::DUTY_W-1:0]     duty_load;
  logic [pmsr_pkg::TOOTH_W-1:0]    tooth_inc;
  logic [pmsr_pkg::WINDOW_W-1:0]   win_len, wcnt_inc;
  logic                            win_end;

  logic                            ph1;
  logic [pmsr_pkg::PHASE_W-1:0]    pc1, len1, pc2;
  logic                            level;

  assign tgt_eff  = (target_rpm_i > pmsr_pkg::TARGET_W'(pmsr_pkg::FULL_SCALE_RPM)) ?
                    '0 : target_rpm_i;
  assign force_hi = (tgt_eff == pmsr_pkg::TARGET_W'(pmsr_pkg::FULL_SCALE_RPM));
  assign force_lo = (tgt_eff == '0);

  // phase lengths from the current duty
  assign hi_prod = HI_PW'(duty_q) * HI_PW'(pmsr_pkg::HI_K);
  assign hi_len  = pmsr_pkg::PHASE_W'(hi_prod >> pmsr_pkg::HI_SHIFT);
  assign lo_len  = pmsr_pkg::PERIOD_TICKS - hi_len;

  // duty loaded by a start transfer
  assign duty_prod = DUTY_PW'(tgt_eff) * DUTY_PW'(pmsr_pkg::DUTY_K);
  assign duty_load = (duty_prod >> pmsr_pkg::DUTY_SH) > DUTY_PW'(pmsr_pkg::DUTY_MAX) ?
                     pmsr_pkg::DUTY_MAX : pmsr_pkg::DUTY_W'(duty_prod >> pmsr_pkg::DUTY_SH);

  // tooth count and speed at window end
  assign tooth_inc = (pulse_edge_i && (tooth_q < pmsr_pkg::TOOTH_MAX)) ?
                     tooth_q + 1'b1 : tooth_q;
  assign rpm_prod  = RPM_PW'(tooth_inc) * RPM_PW'(pmsr_pkg::RPM_K);
  assign rpm_raw   = pmsr_pkg::RPM_RAW_W'(rpm_prod >> pmsr_pkg::RPM_SH);
  assign rpm_sat   = (rpm_raw > pmsr_pkg::RPM_MAX) ? '1 : pmsr_pkg::RPM_W'(rpm_raw);

  assign win_len  = (window_ticks_i == '0) ? pmsr_pkg::WINDOW_W'(1) : window_ticks_i;
  assign wcnt_inc = wcnt_q + 1'b1;
  assign win_end  = (wcnt_inc >= win_len);

  always_comb begin
    phase_d = phase_q;
    pcnt_d  = pcnt_q;
    tooth_d = tooth_q;
    wcnt_d  = wcnt_q;
    duty_d  = duty_q;
    rpm_d   = rpm_q;
    ph1     = phase_q;
    pc1     = pcnt_q;
    len1    = phase_q ? hi_len : lo_len;
    pc2     = '0;
    level   = 1'b0;
    result_o.window_done = 1'b0;

    unique case (mode_i)
      pmsr_pkg::MODE_START: begin
        duty_d  = duty_load;
        phase_d = 1'b0;
        pcnt_d  = '0;
        tooth_d = '0;
        wcnt_d  = '0;
        level   = force_hi ? 1'b1 : 1'b0;
      end
      pmsr_pkg::MODE_TICK: begin
        // an empty phase is skipped at once
        if (len1 == '0) begin
          ph1  = ~phase_q;
          pc1  = '0;
          len1 = ph1 ? hi_len : lo_len;
        end
        level = force_hi ? 1'b1 : (force_lo ? 1'b0 : ph1);
        pc2   = pc1 + 1'b1;
        if (pc2 >= len1) begin
          phase_d = ~ph1;
          pcnt_d  = '0;
        end else begin
          phase_d = ph1;
          pcnt_d  = pc2;
        end

        tooth_d = tooth_inc;
        wcnt_d  = wcnt_inc;
        if (win_end) begin
          rpm_d = rpm_sat;
          if (rpm_sat < pmsr_pkg::RPM_W'(tgt_eff)) begin
            if (duty_q < pmsr_pkg::DUTY_MAX) duty_d = duty_q + 1'b1;
          end else if (rpm_sat > pmsr_pkg::RPM_W'(tgt_eff)) begin
            if (duty_q != '0) duty_d = duty_q - 1'b1;
          end
          tooth_d = '0;
          wcnt_d  = '0;
          result_o.window_done = 1'b1;
        end
      end
      default: begin
      end
    endcase

    result_o.pwm_level    = level;
    result_o.measured_rpm = rpm_d;
    result_o.duty_percent = duty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      pcnt_q  <= '0;
      tooth_q <= '0;
      wcnt_q  <= '0;
      duty_q  <= '0;
      rpm_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pcnt_q  <= pcnt_d;
      tooth_q <= tooth_d;
      wcnt_q  <= wcnt_d;
      duty_q  <= duty_d;
      rpm_q   <= rpm_d;
    end
  end

endmodule

// ===== sv/pmsr_checker.sv =====
// ----------------------------------------------------------------------------
// pmsr_checker
// port-level assertions for the speed regulator, bound to the top level
// ----------------------------------------------------------------------------
`include "pwm_motor_speed_regulator_unit_assert.svh"

module pmsr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [23:0]                 m_axis_tdata,
  input logic                        m_axis_tlast
);

  // stalled result is kept
  `PMSR_ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // empty output register never blocks the input
  `PMSR_ASSERT_DEF(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  // every input transfer yields a result next cycle
  `PMSR_ASSERT_DEF(a_in_to_out, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "no result after input transfer")

  // duty stays within whole percent range
  `PMSR_ASSERT_DEF(a_duty_range, m_axis_tvalid |-> m_axis_tdata[23:17] <= 7'd100, "duty above 100 percent")

  // a start transfer never closes a window
  `PMSR_ASSERT_DEF(a_start_no_win,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == pmsr_pkg::MODE_START) |=> !m_axis_tlast,
    "window closed by start")

endmodule

bind pwm_motor_speed_regulator_unit pmsr_checker u_pmsr_checker (.*);
